@@ design/mbc_pkg.sv @@
// Shared constants, types and rounding function for the biquad cascade.
package mbc_pkg;

  localparam int CHANNELS = 8;
  localparam int STAGES   = 4;
  localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int STG_AW   = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int STG_CW   = $clog2(STAGES + 1);
  localparam int SIG_W    = 24;
  localparam int COEF_W   = 20;
  localparam int SMP_W    = 16;
  localparam int PROD_W   = SIG_W + COEF_W;
  localparam int ACC_W    = 48;
  localparam int NCOEF    = 5;

  localparam logic signed [ACC_W-1:0] ACC_RND = 48'sd32768;
  localparam logic signed [ACC_W-1:0] SIG_MAX = 48'sd8388607;
  localparam logic signed [ACC_W-1:0] SIG_MIN = -48'sd8388608;

  typedef enum logic [1:0] {
    CMD_FILTER = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_GAIN   = 2'd0,
    CFG_STAGES = 2'd1,
    CFG_INIT   = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    SLOT_B0 = 3'd0,
    SLOT_B1 = 3'd1,
    SLOT_B2 = 3'd2,
    SLOT_A1 = 3'd3,
    SLOT_A2 = 3'd4
  } coef_slot_e;

  localparam logic [2:0] POS_A0 = 3'd3;
  localparam logic [2:0] POS_A2 = 3'd5;

  typedef struct packed {
    logic       start;
    logic       clr;
    logic       coef_we;
    coef_slot_e coef_slot;
  } cell_ctrl_t;

  typedef struct packed {
    logic                    done;
    logic                    sat;
    logic signed [SIG_W-1:0] y;
  } cell_res_t;

  typedef struct packed {
    logic                    clip;
    logic signed [SIG_W-1:0] val;
  } rnd_t;

  function automatic rnd_t round_sig(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] t;
    rnd_t r;
    t = (acc + ACC_RND) >>> 16;
    r.clip = 1'b0;
    if (t > SIG_MAX) begin
      r.clip = 1'b1;
      r.val  = SIG_MAX[SIG_W-1:0];
    end else if (t < SIG_MIN) begin
      r.clip = 1'b1;
      r.val  = SIG_MIN[SIG_W-1:0];
    end else begin
      r.val = t[SIG_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ design/multichannel_biquad_cascade_top.sv @@
// Top level of the multichannel biquad cascade: stream ports, registers, sequencing and gain.
// A filter word goes from acceptance through the n section cells in use to a valid output:
// each section cell runs a start and seven steps, then come gain multiply and rounding.
// Only one filter word is in flight; the next waits until its result is loaded for output.
// Coefficient load and clear words are taken in the idle state and give no output.
// Reset is asynchronous, active low: delay state reads as zero, gain 1.0, one stage in use.
module multichannel_biquad_cascade_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // channel[2:0], sample_in[18:3], stage_sel[20:19], coef_pos[23:21], coef_value[43:24]
  input  logic [47:0] s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_channel[2:0], sample_out[18:3]
  output logic [23:0] m_axis_tdata,
  // saturated[0]
  output logic        m_axis_tuser,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [19:0] cfg_data_i
);
  import mbc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_GAIN = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [2:0]               w_ch;
  logic signed [SMP_W-1:0]  w_smp;
  logic [1:0]               w_stg;
  logic [2:0]               w_pos;
  logic signed [COEF_W-1:0] w_coef;
  cmd_e                     w_cmd;
  logic                     acc_in, go_filter, go_load, go_clear;
  logic [2:0]               slot;

  logic signed [COEF_W-1:0] gain_q;
  logic [2:0]               nstg_q;
  logic signed [SMP_W-1:0]  init_q;
  logic signed [SIG_W-1:0]  clr_val_q;
  logic [STG_CW-1:0]        n_q, n_d;
  logic [2:0]               ch_q;
  logic signed [SIG_W-1:0]  x0_q;
  logic                     go_q;
  logic signed [SIG_W-1:0]  y_q;
  logic                     sat_q;
  logic signed [PROD_W-1:0] gprod_q;
  logic signed [PROD_W-1:0] gt;
  logic signed [SMP_W-1:0]  out_val;
  logic                     out_clip;
  logic                     out_vld_q;
  logic [2:0]               out_ch_q;
  logic signed [SMP_W-1:0]  out_smp_q;
  logic                     out_sat_q;
  logic                     load_out;

  cell_ctrl_t               ctrl [STAGES];
  cell_res_t                res [STAGES];
  logic [STAGES-1:0]        done_vec;
  logic [STG_AW-1:0]        last_idx;
  logic                     done_last;

  assign w_ch   = s_axis_tdata[2:0];
  assign w_smp  = s_axis_tdata[18:3];
  assign w_stg  = s_axis_tdata[20:19];
  assign w_pos  = s_axis_tdata[23:21];
  assign w_coef = s_axis_tdata[43:24];
  assign w_cmd  = cmd_e'(s_axis_tuser);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign acc_in        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    go_filter = 1'b0;
    go_load   = 1'b0;
    go_clear  = 1'b0;
    unique case (w_cmd)
      CMD_FILTER: go_filter = acc_in && (32'(w_ch) < CHANNELS);
      CMD_LOAD:   go_load   = acc_in && (32'(w_stg) < STAGES) && (w_pos != POS_A0)
                              && (w_pos <= POS_A2);
      CMD_CLEAR:  go_clear  = acc_in;
      default:    ;
    endcase
  end

  assign slot = (w_pos < POS_A0) ? w_pos : (w_pos - 3'd1);

  always_comb begin
    if (nstg_q == 3'd0) begin
      n_d = STG_CW'(1);
    end else if (32'(nstg_q) > STAGES) begin
      n_d = STG_CW'(STAGES);
    end else begin
      n_d = STG_CW'(nstg_q);
    end
  end

  for (genvar k = 0; k < STAGES; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign ctrl[k].start = go_q;
    end else begin : g_next
      assign ctrl[k].start = res[k-1].done && (k < 32'(n_q));
    end
    assign ctrl[k].clr       = go_clear;
    assign ctrl[k].coef_we   = go_load && (32'(w_stg) == k);
    assign ctrl[k].coef_slot = coef_slot_e'(slot);
    assign done_vec[k]       = res[k].done;

    mbc_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl[k]),
      .ch_i      (CH_AW'(ch_q)),
      .x_i       ((k == 0) ? x0_q : res[(k == 0) ? 0 : k - 1].y),
      .sat_i     ((k == 0) ? 1'b0 : res[(k == 0) ? 0 : k - 1].sat),
      .coef_i    (w_coef),
      .clr_val_i (clr_val_q),
      .res_o     (res[k])
    );
  end

  assign last_idx  = STG_AW'(n_q - STG_CW'(1));
  assign done_last = res[last_idx].done;

  assign gt = (gprod_q + 44'sd8388608) >>> 24;
  always_comb begin
    out_clip = 1'b1;
    if (gt > 44'sd32767) begin
      out_val = 16'sh7FFF;
    end else if (gt < -44'sd32768) begin
      out_val = -16'sh8000;
    end else begin
      out_val  = gt[SMP_W-1:0];
      out_clip = 1'b0;
    end
  end

  assign load_out = (state_q == ST_FIN) && (!out_vld_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (go_filter) state_d = ST_RUN;
      ST_RUN:  if (done_last) state_d = ST_GAIN;
      ST_GAIN: state_d = ST_FIN;
      ST_FIN:  if (load_out) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      go_q      <= 1'b0;
      out_vld_q <= 1'b0;
      gain_q    <= 20'sd65536;
      nstg_q    <= 3'd1;
      init_q    <= '0;
      clr_val_q <= '0;
    end else begin
      state_q <= state_d;
      go_q    <= go_filter;
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_GAIN:   gain_q <= cfg_data_i;
          CFG_STAGES: nstg_q <= cfg_data_i[2:0];
          CFG_INIT:   init_q <= cfg_data_i[SMP_W-1:0];
          default:    ;
        endcase
      end
      if (go_clear) begin
        clr_val_q <= {init_q, 8'd0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_filter) begin
      ch_q <= w_ch;
      x0_q <= {w_smp, 8'd0};
      n_q  <= n_d;
    end
    if (state_q == ST_RUN && done_last) begin
      y_q   <= res[last_idx].y;
      sat_q <= res[last_idx].sat;
    end
    if (state_q == ST_GAIN) begin
      gprod_q <= y_q * gain_q;
    end
    if (load_out) begin
      out_ch_q  <= ch_q;
      out_smp_q <= out_val;
      out_sat_q <= sat_q | out_clip;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'd0, out_smp_q, out_ch_q};
  assign m_axis_tuser  = out_sat_q;

  a_one_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(done_vec))
    else $error("more than one section finished in the same cycle");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (done_vec == '0))
    else $error("section finished while no word was in flight");

  a_fin_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_vld_q && !m_axis_tready) |=> (state_q == ST_FIN))
    else $error("result left the gain stage while the output register was full");

  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_filter |=> (state_q == ST_RUN) && ctrl[0].start)
    else $error("filter word did not start the first section");

endmodule

@@ design/mbc_cell.sv @@
// One biquad section: coefficients, per-channel delay memory and a serial multiply-accumulate.
module mbc_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mbc_pkg::cell_ctrl_t                 ctrl_i,
  input  logic [mbc_pkg::CH_AW-1:0]           ch_i,
  input  logic signed [mbc_pkg::SIG_W-1:0]    x_i,
  input  logic                                sat_i,
  input  logic signed [mbc_pkg::COEF_W-1:0]   coef_i,
  input  logic signed [mbc_pkg::SIG_W-1:0]    clr_val_i,
  output mbc_pkg::cell_res_t                  res_o
);
  import mbc_pkg::*;

  localparam logic [2:0] STEP_A1   = 3'd0;
  localparam logic [2:0] STEP_A2   = 3'd1;
  localparam logic [2:0] STEP_U    = 3'd2;
  localparam logic [2:0] STEP_B0   = 3'd3;
  localparam logic [2:0] STEP_B1   = 3'd4;
  localparam logic [2:0] STEP_B2   = 3'd5;
  localparam logic [2:0] STEP_LAST = 3'd6;

  logic signed [COEF_W-1:0] coef_q [NCOEF];
  logic [2*SIG_W-1:0]       mem [CHANNELS];
  logic [2*SIG_W-1:0]       rd_q;
  logic [CHANNELS-1:0]      fresh_q;
  logic                     fresh_rd_q;
  logic                     busy_q, done_q;
  logic [2:0]               cnt_q;
  logic signed [SIG_W-1:0]  x_q, u_q, y_q;
  logic                     sat_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d, prod_ext;
  logic signed [SIG_W-1:0]  r0, r1, mb;
  logic signed [COEF_W-1:0] ma;
  logic signed [PROD_W-1:0] prod;
  rnd_t                     rnd;

  assign r0 = fresh_rd_q ? clr_val_i : rd_q[SIG_W-1:0];
  assign r1 = fresh_rd_q ? clr_val_i : rd_q[2*SIG_W-1:SIG_W];

  always_comb begin
    unique case (cnt_q)
      STEP_A1: begin ma = coef_q[SLOT_A1]; mb = r0;  end
      STEP_A2: begin ma = coef_q[SLOT_A2]; mb = r1;  end
      STEP_B1: begin ma = coef_q[SLOT_B1]; mb = r0;  end
      STEP_B2: begin ma = coef_q[SLOT_B2]; mb = r1;  end
      default: begin ma = coef_q[SLOT_B0]; mb = u_q; end
    endcase
  end

  assign prod     = ma * mb;
  assign prod_ext = ACC_W'(prod);
  assign rnd      = round_sig(acc_q);

  always_comb begin
    unique case (cnt_q)
      STEP_A1:          acc_d = (ACC_W'(x_q) <<< 16) - prod_ext;
      STEP_A2:          acc_d = acc_q - prod_ext;
      STEP_B0:          acc_d = prod_ext;
      STEP_B1, STEP_B2: acc_d = acc_q + prod_ext;
      default:          acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= STEP_A1;
      fresh_q <= '1;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= STEP_A1;
      end else if (busy_q) begin
        if (cnt_q == STEP_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 3'd1;
        end
      end
      if (ctrl_i.clr) begin
        fresh_q <= '1;
      end else if (busy_q && cnt_q == STEP_LAST) begin
        fresh_q[ch_i] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.coef_we) begin
      coef_q[ctrl_i.coef_slot] <= coef_i;
    end
    if (ctrl_i.start) begin
      x_q        <= x_i;
      sat_q      <= sat_i;
      rd_q       <= mem[ch_i];
      fresh_rd_q <= fresh_q[ch_i];
    end else if (busy_q) begin
      acc_q <= acc_d;
      if (cnt_q == STEP_U) begin
        u_q   <= rnd.val;
        sat_q <= sat_q | rnd.clip;
      end
      if (cnt_q == STEP_LAST) begin
        y_q         <= rnd.val;
        sat_q       <= sat_q | rnd.clip;
        mem[ch_i]   <= {r0, u_q};
      end
    end
  end

  assign res_o.done = done_q;
  assign res_o.sat  = sat_q;
  assign res_o.y    = y_q;

endmodule
